// ===== design/jrms_pkg.sv =====
// jrms_pkg: types, constants and helper functions for the jam recovery motor sequencer
// used by every module of the block and by the channel interfaces' users

package jrms_pkg;

   // timing and detection constants
   localparam logic [31:0] GRACE_MS        = 32'd1500;
   localparam logic [31:0] PAUSE_MS        = 32'd500;
   localparam logic [15:0] SENSOR_LIMIT_MA = 16'd30000;
   localparam logic [8:0]  DEFICIT_RATIO_Q8 = 9'd128;

   localparam logic [19:0] TORQUE_MAX = 20'hFFFFF;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // configuration register indexes
   localparam logic [2:0] REG_DRIVE_READY    = 3'd0;
   localparam logic [2:0] REG_NO_LOAD_CURR   = 3'd1;
   localparam logic [2:0] REG_TORQUE_GAIN    = 3'd2;
   localparam logic [2:0] REG_RUN_SPEED      = 3'd3;
   localparam logic [2:0] REG_JAM_TORQUE     = 3'd4;
   localparam logic [2:0] REG_OVERLOAD_TIME  = 3'd5;
   localparam logic [2:0] REG_REVERSE_TIME   = 3'd6;
   localparam logic [2:0] REG_RETRY_LIMIT    = 3'd7;

   // event opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // reported mode codes
   localparam logic [2:0] CODE_STOP  = 3'd0;
   localparam logic [2:0] CODE_FWD   = 3'd1;
   localparam logic [2:0] CODE_DWELL = 3'd2;
   localparam logic [2:0] CODE_RETRY = 3'd3;
   localparam logic [2:0] CODE_REV   = 3'd4;
   localparam logic [2:0] CODE_FAULT = 3'd5;

   typedef enum logic [5:0] {
      MODE_STOP  = 6'b000001,
      MODE_FWD   = 6'b000010,
      MODE_DWELL = 6'b000100,
      MODE_RETRY = 6'b001000,
      MODE_REV   = 6'b010000,
      MODE_FAULT = 6'b100000
   } mode_type;

   typedef struct packed {
      logic        drive_ready;
      logic [15:0] no_load_current;
      logic [31:0] torque_gain;
      logic [7:0]  run_speed;
      logic [19:0] jam_torque;
      logic [15:0] overload_time;
      logic [15:0] reverse_time;
      logic [7:0]  retry_limit;
   } jrms_cfg_type;

   // classified event handed from the front end to the sequencer
   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic        permission_ok;
      logic        heater_or_screw_on;
      logic        tach_fail;
      logic        lockout_confirmed;
      logic [19:0] torque;
      logic        over_cond;
   } jrms_item_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      case (m)
         MODE_STOP:  c = CODE_STOP;
         MODE_FWD:   c = CODE_FWD;
         MODE_DWELL: c = CODE_DWELL;
         MODE_RETRY: c = CODE_RETRY;
         MODE_REV:   c = CODE_REV;
         MODE_FAULT: c = CODE_FAULT;
         default:    c = CODE_STOP;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] mode_target(input mode_type m, input logic [7:0] run_speed);
      logic [7:0] t;
      case (m)
         MODE_FWD, MODE_DWELL: t = run_speed;
         MODE_REV:             t = {1'b0, run_speed[7:1]};
         default:              t = 8'd0;
      endcase
      return t;
   endfunction

   // deadline counts as reached within half the time wrap
   function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
      logic [31:0] d;
      d = now - deadline;
      return ~d[31];
   endfunction

endpackage

// ===== design/jrms_if.sv =====
// jrms_req_if, jrms_rsp_if: valid/ready channels of the jam recovery motor sequencer
// no dependencies

interface jrms_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] now_ms;
   logic [15:0] current_ma;
   logic [9:0]  cutter_speed;
   logic        permission_ok;
   logic        heater_or_screw_on;
   logic        tach_fail;
   logic        lockout_confirmed;

   modport source (
      output valid, opcode, now_ms, current_ma, cutter_speed,
             permission_ok, heater_or_screw_on, tach_fail, lockout_confirmed,
      input  ready
   );
   modport sink (
      input  valid, opcode, now_ms, current_ma, cutter_speed,
             permission_ok, heater_or_screw_on, tach_fail, lockout_confirmed,
      output ready
   );
endinterface

interface jrms_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [7:0]  target_speed;
   logic        drive_enable;
   logic        reverse_dir;
   logic [7:0]  retry_total;
   logic [19:0] torque_estimate;
   logic        accepted;

   modport source (
      output valid, mode, target_speed, drive_enable, reverse_dir,
             retry_total, torque_estimate, accepted,
      input  ready
   );
   modport sink (
      input  valid, mode, target_speed, drive_enable, reverse_dir,
             retry_total, torque_estimate, accepted,
      output ready
   );
endinterface

// ===== design/jrms_front.sv =====
// jrms_front: accepts events, estimates cutter torque and classifies overload conditions
// depends on jrms_pkg and jrms_req_if

module jrms_front import jrms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  jrms_cfg_type  cfg,
   jrms_req_if.sink      req_ch,
   output logic          item_valid,
   output jrms_item_type item,
   input  logic          item_ready
);

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  opcode_ff;
   logic [31:0] now_ff;
   logic        perm_ff, heat_ff, tach_ff, lock_ff;
   logic        stall_cond_ff;
   logic [47:0] prod_ff;

   logic        s1_load;
   logic [15:0] load;
   logic [16:0] deficit_lim;
   logic        stall_cond;
   logic [31:0] shifted;
   logic [19:0] torque;

   assign s1_load      = ~s1_valid_ff | item_ready;
   assign req_ch.ready = s1_load;
   assign s1_valid_in  = s1_load ? req_ch.valid : s1_valid_ff;

   // load current above idle, zero while not calibrated
   assign load = (cfg.drive_ready && req_ch.current_ma > cfg.no_load_current) ?
                 req_ch.current_ma - cfg.no_load_current : 16'd0;

   assign deficit_lim = 17'(DEFICIT_RATIO_Q8) * 17'(cfg.run_speed);
   // current pegged at the sensor limit while the cutter runs slow
   assign stall_cond  = (req_ch.current_ma >= SENSOR_LIMIT_MA) &&
                        ({req_ch.cutter_speed, 8'b0} < {1'b0, deficit_lim});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         opcode_ff     <= req_ch.opcode;
         now_ff        <= req_ch.now_ms;
         perm_ff       <= req_ch.permission_ok;
         heat_ff       <= req_ch.heater_or_screw_on;
         tach_ff       <= req_ch.tach_fail;
         lock_ff       <= req_ch.lockout_confirmed;
         stall_cond_ff <= stall_cond;
         prod_ff       <= 48'(load) * 48'(cfg.torque_gain);
      end
   end

   // drop the fraction bits and saturate
   assign shifted = prod_ff[47:16];
   assign torque  = (|shifted[31:20]) ? TORQUE_MAX : shifted[19:0];

   assign item_valid              = s1_valid_ff;
   assign item.opcode             = opcode_ff;
   assign item.now_ms             = now_ff;
   assign item.permission_ok      = perm_ff;
   assign item.heater_or_screw_on = heat_ff;
   assign item.tach_fail          = tach_ff;
   assign item.lockout_confirmed  = lock_ff;
   assign item.torque             = torque;
   assign item.over_cond          = (torque >= cfg.jam_torque) | stall_cond_ff;

endmodule

// ===== design/jrms_queue.sv =====
// jrms_queue: short first-in first-out queue of classified events
// depends on jrms_pkg

module jrms_queue import jrms_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_valid,
   input  jrms_item_type wr_item,
   output logic          wr_ready,
   output logic          rd_valid,
   output jrms_item_type rd_item,
   input  logic          rd_ready
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   jrms_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != CNT_FULL);
   assign rd_valid = (count_ff != '0);
   assign rd_item  = entry_ff[rd_ptr_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ===== design/jrms_back.sv =====
// jrms_back: jam recovery sequencer state and registered result stage
// depends on jrms_pkg and jrms_rsp_if

module jrms_back import jrms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  jrms_cfg_type  cfg,
   input  logic          item_valid,
   input  jrms_item_type item,
   output logic          item_ready,
   jrms_rsp_if.source    rsp_ch
);

   mode_type    mode_ff, mode_in;
   logic [7:0]  retries_ff, retries_in;
   logic        ovl_ff, ovl_in;
   logic [31:0] fwd_start_ff, fwd_start_in;
   logic [31:0] ovl_start_ff, ovl_start_in;
   logic [31:0] pause_dl_ff, pause_dl_in;
   logic [31:0] rev_dl_ff, rev_dl_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  mode_out_ff;
   logic [7:0]  target_ff;
   logic        enable_ff, rev_dir_ff, acc_ff;
   logic [7:0]  retry_out_ff;
   logic [19:0] torque_ff;

   logic        pop;
   logic [7:0]  target;
   logic        enable, acc, over;
   logic [31:0] since_fwd, since_ovl;

   assign item_ready   = ~rsp_valid_ff | rsp_ch.ready;
   assign pop          = item_valid & item_ready;
   assign rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff & ~rsp_ch.ready);

   assign since_fwd = item.now_ms - fwd_start_ff;
   assign since_ovl = item.now_ms - ovl_start_ff;
   assign over      = (since_fwd >= GRACE_MS) & item.over_cond;

   always_comb begin
      mode_in      = mode_ff;
      retries_in   = retries_ff;
      ovl_in       = ovl_ff;
      fwd_start_in = fwd_start_ff;
      ovl_start_in = ovl_start_ff;
      pause_dl_in  = pause_dl_ff;
      rev_dl_in    = rev_dl_ff;
      target       = 8'd0;
      acc          = 1'b0;
      enable       = 1'b0;

      case (item.opcode)
         OP_START: begin
            if (cfg.drive_ready && item.permission_ok && !item.heater_or_screw_on &&
                mode_ff != MODE_FAULT) begin
               mode_in      = MODE_FWD;
               retries_in   = 8'd0;
               ovl_in       = 1'b0;
               fwd_start_in = item.now_ms;
               acc          = 1'b1;
            end
            target = mode_target(mode_in, cfg.run_speed);
         end
         OP_STOP: begin
            mode_in = MODE_STOP;
            ovl_in  = 1'b0;
         end
         OP_CLEAR: begin
            if (mode_ff == MODE_FAULT && item.lockout_confirmed && item.permission_ok &&
                !item.heater_or_screw_on) begin
               mode_in    = MODE_STOP;
               ovl_in     = 1'b0;
               retries_in = 8'd0;
               acc        = 1'b1;
            end
            target = mode_target(mode_in, cfg.run_speed);
         end
         OP_TICK: begin
            if (mode_ff inside {MODE_FWD, MODE_DWELL, MODE_RETRY, MODE_REV}) begin
               if (!item.permission_ok || item.heater_or_screw_on) begin
                  // interlock dropped while running
                  mode_in = MODE_FAULT;
                  ovl_in  = 1'b0;
               end else begin
                  case (mode_ff)
                     MODE_RETRY: begin
                        if (reached(item.now_ms, pause_dl_ff)) begin
                           if (retries_ff != 8'hFF) begin
                              retries_in = retries_ff + 8'd1;
                           end
                           mode_in   = MODE_REV;
                           rev_dl_in = item.now_ms + 32'(cfg.reverse_time);
                        end
                     end
                     MODE_REV: begin
                        if (reached(item.now_ms, rev_dl_ff)) begin
                           if (retries_ff >= cfg.retry_limit) begin
                              mode_in = MODE_FAULT;
                              ovl_in  = 1'b0;
                           end else begin
                              mode_in      = MODE_FWD;
                              ovl_in       = 1'b0;
                              fwd_start_in = item.now_ms;
                           end
                        end
                        // retries exhausted still reports run_speed
                        target = (mode_in == MODE_REV) ? {1'b0, cfg.run_speed[7:1]} :
                                 cfg.run_speed;
                     end
                     default: begin
                        // forward or overload dwell
                        target = cfg.run_speed;
                        if (!over) begin
                           ovl_in = 1'b0;
                           if (mode_ff == MODE_DWELL) begin
                              mode_in = MODE_FWD;
                           end
                        end else if (!ovl_ff) begin
                           ovl_in       = 1'b1;
                           ovl_start_in = item.now_ms;
                           mode_in      = MODE_DWELL;
                        end else if (since_ovl >= 32'(cfg.overload_time)) begin
                           mode_in     = MODE_RETRY;
                           pause_dl_in = item.now_ms + PAUSE_MS;
                           ovl_in      = 1'b0;
                           target      = 8'd0;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase

      enable = (mode_in inside {MODE_FWD, MODE_DWELL, MODE_REV}) && (target != 8'd0);

      // tach loss only counts while the drive is actually enabled
      if (item.opcode == OP_TICK && enable && item.tach_fail) begin
         mode_in = MODE_FAULT;
         ovl_in  = 1'b0;
         target  = 8'd0;
         enable  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STOP;
         retries_ff   <= 8'd0;
         ovl_ff       <= 1'b0;
         fwd_start_ff <= 32'd0;
         ovl_start_ff <= 32'd0;
         pause_dl_ff  <= 32'd0;
         rev_dl_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            mode_ff      <= mode_in;
            retries_ff   <= retries_in;
            ovl_ff       <= ovl_in;
            fwd_start_ff <= fwd_start_in;
            ovl_start_ff <= ovl_start_in;
            pause_dl_ff  <= pause_dl_in;
            rev_dl_ff    <= rev_dl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mode_out_ff  <= mode_code(mode_in);
         target_ff    <= target;
         enable_ff    <= enable;
         rev_dir_ff   <= (mode_in == MODE_REV);
         retry_out_ff <= retries_in;
         torque_ff    <= item.torque;
         acc_ff       <= acc;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.mode            = mode_out_ff;
   assign rsp_ch.target_speed    = target_ff;
   assign rsp_ch.drive_enable    = enable_ff;
   assign rsp_ch.reverse_dir     = rev_dir_ff;
   assign rsp_ch.retry_total     = retry_out_ff;
   assign rsp_ch.torque_estimate = torque_ff;
   assign rsp_ch.accepted        = acc_ff;

endmodule

// ===== design/jam_recovery_motor_sequencer.sv =====
// Shredder drive supervisor: jam detection, retry sequencing and fault latching.
// Events (tick, start, stop, clear fault) arrive on req_ch; one result per event
// leaves on rsp_ch, in order. Both are valid/ready channels; a transfer happens
// when valid and ready are high at a rising clock edge.
// Configuration registers are written through csr_we/csr_index/csr_wdata, one per
// cycle, while no event is in flight.
// An accepted event passes the torque multiply stage, then a queue entry, then the
// result register, which loads from the queue head.
// Throughput: one event per cycle unless rsp_ch stalls, set by the sequencer state update.
// When rsp_ch stalls, the result register holds, the queue of QUEUE_DEPTH entries
// fills, then req_ch.ready drops; up to QUEUE_DEPTH + 2 events are held inside.
// Synchronous reset puts the drive in stop mode with no retries used, empties the
// queue and restores the configuration and control registers to their reset values.
// depends on jrms_pkg, jrms_if, jrms_front, jrms_queue, jrms_back

module jam_recovery_motor_sequencer import jrms_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   jrms_req_if.sink    req_ch,
   jrms_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   jrms_cfg_type  cfg_ff;
   jrms_cfg_type  cfg_in;

   logic          fr_valid, fr_ready;
   jrms_item_type fr_item;
   logic          bk_valid, bk_ready;
   jrms_item_type bk_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DRIVE_READY:   cfg_in.drive_ready     = csr_wdata[0];
            REG_NO_LOAD_CURR:  cfg_in.no_load_current = csr_wdata[15:0];
            REG_TORQUE_GAIN:   cfg_in.torque_gain     = csr_wdata;
            REG_RUN_SPEED:     cfg_in.run_speed       = csr_wdata[7:0];
            REG_JAM_TORQUE:    cfg_in.jam_torque      = csr_wdata[19:0];
            REG_OVERLOAD_TIME: cfg_in.overload_time   = csr_wdata[15:0];
            REG_REVERSE_TIME:  cfg_in.reverse_time    = csr_wdata[15:0];
            REG_RETRY_LIMIT:   cfg_in.retry_limit     = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_ready     <= 1'b0;
         cfg_ff.no_load_current <= 16'd0;
         cfg_ff.torque_gain     <= 32'd0;
         cfg_ff.run_speed       <= 8'd0;
         cfg_ff.jam_torque      <= TORQUE_MAX;
         cfg_ff.overload_time   <= 16'd1000;
         cfg_ff.reverse_time    <= 16'd1000;
         cfg_ff.retry_limit     <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jrms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .item_valid (fr_valid),
      .item       (fr_item),
      .item_ready (fr_ready)
   );

   jrms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_item  (fr_item),
      .wr_ready (fr_ready),
      .rd_valid (bk_valid),
      .rd_item  (bk_item),
      .rd_ready (bk_ready)
   );

   jrms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (bk_valid),
      .item       (bk_item),
      .item_ready (bk_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== tb/jam_recovery_motor_sequencer_test.sv =====
// testbench for jam_recovery_motor_sequencer: directed and random event streams, results
// checked in order against a cycle-free model of the drive supervisor
// depends on jrms_pkg, jrms_req_if, jrms_rsp_if and the block itself

module jam_recovery_motor_sequencer_test import jrms_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned MAX_REPORTS      = 40;
   localparam int unsigned SETTLE_CYCLES    = 4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [15:0] current_ma;
      logic [9:0]  cutter_speed;
      logic        permission_ok;
      logic        heater_or_screw_on;
      logic        tach_fail;
      logic        lockout_confirmed;
   } drive_event_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  target_speed;
      logic        drive_enable;
      logic        reverse_dir;
      logic [7:0]  retry_total;
      logic [19:0] torque_estimate;
      logic        accepted;
   } drive_status_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   jrms_req_if req_ch ();
   jrms_rsp_if rsp_ch ();

   jam_recovery_motor_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // supervisor model state and its copy of the registers
   jrms_cfg_type sq_cfg;
   logic [2:0]   sq_mode      = CODE_STOP;
   logic [7:0]   sq_retries   = 8'd0;
   logic         sq_overload  = 1'b0;
   logic [31:0]  sq_fwd_since = 32'd0;
   logic [31:0]  sq_ovl_since = 32'd0;
   logic [31:0]  sq_pause_end = 32'd0;
   logic [31:0]  sq_rev_end   = 32'd0;

   drive_status_type pending_status [$];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned long_hold_req = 0;
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   logic [31:0] run_ms        = 32'd0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic jrms_cfg_type make_config(input logic ready, input logic [15:0] idle_ma,
         input logic [31:0] gain, input logic [7:0] speed, input logic [19:0] jam,
         input logic [15:0] ovl_len, input logic [15:0] rev_len,
         input logic [7:0] limit);
      jrms_cfg_type c;
      c.drive_ready     = ready;
      c.no_load_current = idle_ma;
      c.torque_gain     = gain;
      c.run_speed       = speed;
      c.jam_torque      = jam;
      c.overload_time   = ovl_len;
      c.reverse_time    = rev_len;
      c.retry_limit     = limit;
      return c;
   endfunction

   function automatic jrms_cfg_type random_config();
      return make_config($urandom_range(9) != 0, 16'($urandom_range(3000)),
         32'($urandom_range(32'h0003_0000, 32'h0000_4000)), 8'($urandom_range(255)),
         20'($urandom_range(60000, 4000)), 16'($urandom_range(1500)),
         16'($urandom_range(2000)), 8'($urandom_range(4)));
   endfunction

   function automatic drive_event_type make_event(input logic [1:0] op,
         input logic [31:0] now, input logic [15:0] cur, input logic [9:0] spd,
         input logic perm, input logic heat, input logic tach, input logic lock);
      drive_event_type ev;
      ev.opcode             = op;
      ev.now_ms             = now;
      ev.current_ma         = cur;
      ev.cutter_speed       = spd;
      ev.permission_ok      = perm;
      ev.heater_or_screw_on = heat;
      ev.tach_fail          = tach;
      ev.lockout_confirmed  = lock;
      return ev;
   endfunction

   function automatic logic [7:0] commanded_speed();
      if (sq_mode == CODE_FWD || sq_mode == CODE_DWELL) return sq_cfg.run_speed;
      if (sq_mode == CODE_REV) return sq_cfg.run_speed >> 1;
      return 8'd0;
   endfunction

   function automatic logic deadline_passed(input logic [31:0] now, input logic [31:0] limit);
      logic [31:0] diff;
      diff = now - limit;
      return diff < 32'h8000_0000;
   endfunction

   // advances the model by one event and returns the status it reports
   function automatic drive_status_type predict_status(input drive_event_type ev);
      drive_status_type st;
      logic [63:0]   load;
      logic [63:0]   gain;
      logic [63:0]   product;
      logic [19:0]   torque;
      logic [7:0]    target;
      logic [31:0]   spd_q8;
      logic [31:0]   floor_q8;
      logic          over;
      logic          enable;
      logic          accepted;
      logic          interlock_ok;

      torque = 20'd0;
      if (sq_cfg.drive_ready && ev.current_ma > sq_cfg.no_load_current) begin
         load    = 64'(ev.current_ma - sq_cfg.no_load_current);
         gain    = 64'(sq_cfg.torque_gain);
         product = (load * gain) >> 16;
         torque  = (product > 64'(TORQUE_MAX)) ? TORQUE_MAX : product[19:0];
      end
      accepted     = 1'b0;
      target       = 8'd0;
      interlock_ok = ev.permission_ok && !ev.heater_or_screw_on;

      case (ev.opcode)
         OP_START: begin
            if (sq_cfg.drive_ready && interlock_ok && sq_mode != CODE_FAULT) begin
               sq_mode      = CODE_FWD;
               sq_retries   = 8'd0;
               sq_overload  = 1'b0;
               sq_fwd_since = ev.now_ms;
               accepted     = 1'b1;
            end
            target = commanded_speed();
         end
         OP_STOP: begin
            sq_mode     = CODE_STOP;
            sq_overload = 1'b0;
         end
         OP_CLEAR: begin
            if (sq_mode == CODE_FAULT && ev.lockout_confirmed && interlock_ok) begin
               sq_mode     = CODE_STOP;
               sq_overload = 1'b0;
               sq_retries  = 8'd0;
               accepted    = 1'b1;
            end
            target = commanded_speed();
         end
         default: begin
            if (sq_mode == CODE_STOP || sq_mode == CODE_FAULT) begin
               target = 8'd0;
            end else if (!interlock_ok) begin
               sq_mode     = CODE_FAULT;
               sq_overload = 1'b0;
            end else if (sq_mode == CODE_RETRY) begin
               if (deadline_passed(ev.now_ms, sq_pause_end)) begin
                  if (sq_retries != 8'hFF) sq_retries = sq_retries + 8'd1;
                  sq_mode    = CODE_REV;
                  sq_rev_end = ev.now_ms + 32'(sq_cfg.reverse_time);
               end
            end else if (sq_mode == CODE_REV) begin
               if (deadline_passed(ev.now_ms, sq_rev_end)) begin
                  if (sq_retries >= sq_cfg.retry_limit) begin
                     sq_mode     = CODE_FAULT;
                     sq_overload = 1'b0;
                  end else begin
                     sq_mode      = CODE_FWD;
                     sq_overload  = 1'b0;
                     sq_fwd_since = ev.now_ms;
                  end
               end
               // exhausted retries still report run speed, with the drive off
               target = (sq_mode == CODE_REV) ? sq_cfg.run_speed >> 1 : sq_cfg.run_speed;
            end else begin
               spd_q8   = ev.cutter_speed * 32'd256;
               floor_q8 = 32'(DEFICIT_RATIO_Q8) * 32'(sq_cfg.run_speed);
               over = (ev.now_ms - sq_fwd_since) >= GRACE_MS &&
                      (torque >= sq_cfg.jam_torque ||
                       (ev.current_ma >= SENSOR_LIMIT_MA && spd_q8 < floor_q8));
               if (!over) begin
                  sq_overload = 1'b0;
                  if (sq_mode == CODE_DWELL) sq_mode = CODE_FWD;
               end else if (!sq_overload) begin
                  sq_overload  = 1'b1;
                  sq_ovl_since = ev.now_ms;
                  sq_mode      = CODE_DWELL;
               end else if ((ev.now_ms - sq_ovl_since) >= 32'(sq_cfg.overload_time)) begin
                  sq_mode      = CODE_RETRY;
                  sq_pause_end = ev.now_ms + PAUSE_MS;
                  sq_overload  = 1'b0;
               end
               target = (sq_mode == CODE_RETRY) ? 8'd0 : sq_cfg.run_speed;
            end
         end
      endcase

      enable = (sq_mode == CODE_FWD || sq_mode == CODE_DWELL || sq_mode == CODE_REV) &&
               target != 8'd0;
      if (ev.opcode == OP_TICK && enable && ev.tach_fail) begin
         sq_mode     = CODE_FAULT;
         sq_overload = 1'b0;
         target      = 8'd0;
         enable      = 1'b0;
      end

      st.mode            = sq_mode;
      st.target_speed    = target;
      st.drive_enable    = enable;
      st.reverse_dir     = (sq_mode == CODE_REV);
      st.retry_total     = sq_retries;
      st.torque_estimate = torque;
      st.accepted        = accepted;
      return st;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got_v,
         input logic [63:0] want_v);
      if (error_count < MAX_REPORTS)
         $display("mismatch in %s: got %0h, expected %0h, cycle %0d",
                  what, got_v, want_v, cycle_count);
      error_count++;
   endtask

   task automatic check_status(input drive_status_type got);
      drive_status_type want;
      if (pending_status.size() == 0) begin
         report_mismatch("result with nothing pending", 64'(got), 64'd0);
      end else begin
         want = pending_status.pop_front();
         if (got.mode !== want.mode)
            report_mismatch("mode", 64'(got.mode), 64'(want.mode));
         if (got.target_speed !== want.target_speed)
            report_mismatch("target_speed", 64'(got.target_speed), 64'(want.target_speed));
         if (got.drive_enable !== want.drive_enable)
            report_mismatch("drive_enable", 64'(got.drive_enable), 64'(want.drive_enable));
         if (got.reverse_dir !== want.reverse_dir)
            report_mismatch("reverse_dir", 64'(got.reverse_dir), 64'(want.reverse_dir));
         if (got.retry_total !== want.retry_total)
            report_mismatch("retry_total", 64'(got.retry_total), 64'(want.retry_total));
         if (got.torque_estimate !== want.torque_estimate)
            report_mismatch("torque_estimate", 64'(got.torque_estimate),
                            64'(want.torque_estimate));
         if (got.accepted !== want.accepted)
            report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
      end
   endtask

   // result side: checks every transfer and drives ready, with an occasional long hold-off
   initial begin : status_sink
      int unsigned      hold_left;
      int unsigned      hold_seen;
      drive_status_type got;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.mode            = rsp_ch.mode;
            got.target_speed    = rsp_ch.target_speed;
            got.drive_enable    = rsp_ch.drive_enable;
            got.reverse_dir     = rsp_ch.reverse_dir;
            got.retry_total     = rsp_ch.retry_total;
            got.torque_estimate = rsp_ch.torque_estimate;
            got.accepted        = rsp_ch.accepted;
            check_status(got);
         end
         if (long_hold_req != hold_seen) begin
            hold_seen = long_hold_req;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // offers one event, waits for its transfer and records the expected status;
   // valid stays high afterwards so back-to-back events follow without a gap
   task automatic send_event(input drive_event_type ev);
      int unsigned gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid              <= 1'b1;
      req_ch.opcode             <= ev.opcode;
      req_ch.now_ms             <= ev.now_ms;
      req_ch.current_ma         <= ev.current_ma;
      req_ch.cutter_speed       <= ev.cutter_speed;
      req_ch.permission_ok      <= ev.permission_ok;
      req_ch.heater_or_screw_on <= ev.heater_or_screw_on;
      req_ch.tach_fail          <= ev.tach_fail;
      req_ch.lockout_confirmed  <= ev.lockout_confirmed;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_status.push_back(predict_status(ev));
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input jrms_cfg_type c);
      logic [31:0] reg_value [8];
      settle();
      reg_value[REG_DRIVE_READY]   = {31'd0, c.drive_ready};
      reg_value[REG_NO_LOAD_CURR]  = {16'd0, c.no_load_current};
      reg_value[REG_TORQUE_GAIN]   = c.torque_gain;
      reg_value[REG_RUN_SPEED]     = {24'd0, c.run_speed};
      reg_value[REG_JAM_TORQUE]    = {12'd0, c.jam_torque};
      reg_value[REG_OVERLOAD_TIME] = {16'd0, c.overload_time};
      reg_value[REG_REVERSE_TIME]  = {16'd0, c.reverse_time};
      reg_value[REG_RETRY_LIMIT]   = {24'd0, c.retry_limit};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= reg_value[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      sq_cfg = c;
   endtask

   // mostly start-then-tick runs with jam or clean load; a share of fully random events
   task automatic drive_runs(input int unsigned count);
      drive_event_type ev;
      int unsigned     ticks_left;
      bit              jammed;
      ticks_left = 0;
      jammed     = 1'b0;
      for (int n = 0; n < count; n++) begin
         ev = make_event(OP_TICK, run_ms, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0);
         if ($urandom_range(99) < 8) begin
            ev = {$urandom, $urandom};
         end else if (ticks_left == 0) begin
            if (sq_mode == CODE_FAULT) begin
               ev.opcode            = OP_CLEAR;
               ev.lockout_confirmed = ($urandom_range(4) != 0);
               ev.permission_ok     = ($urandom_range(19) != 0);
            end else begin
               ev.opcode             = OP_START;
               ev.permission_ok      = ($urandom_range(19) != 0);
               ev.heater_or_screw_on = ($urandom_range(19) == 0);
               ticks_left            = $urandom_range(60, 8);
               jammed                = ($urandom_range(99) < 60);
            end
         end else begin
            ticks_left--;
            if (sq_mode == CODE_FAULT && ticks_left > 3) ticks_left = 3;
            run_ms                = run_ms + $urandom_range(400);
            ev.now_ms             = run_ms;
            ev.current_ma         = jammed ? 16'($urandom_range(65535, 28000))
                                           : 16'($urandom_range(12000));
            ev.cutter_speed       = jammed ? 10'($urandom_range(40))
                                           : 10'($urandom_range(1023, 100));
            ev.permission_ok      = ($urandom_range(99) != 0);
            ev.heater_or_screw_on = ($urandom_range(99) == 0);
            ev.tach_fail          = ($urandom_range(99) < 2);
            ev.lockout_confirmed  = 1'($urandom_range(1));
            if ($urandom_range(99) < 3) ev.opcode = OP_STOP;
            else if ($urandom_range(99) < 2) ev.opcode = OP_START;
         end
         send_event(ev);
      end
   endtask

   // nothing written yet: drive not ready, so start is refused and torque reads zero
   task automatic test_reset_defaults();
      send_event(make_event(OP_TICK, 32'd0, 16'd40000, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_START, 32'd10, 16'd40000, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_CLEAR, 32'd20, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b1));
   endtask

   // one jam through dwell, pause, reverse and exhaustion; time wraps on the way;
   // then the fault entries and exits: clear, tach loss, interlock loss, stop from fault
   task automatic test_retry_sequence();
      logic [31:0] t;
      t = 32'hFFFF_FA00;
      apply_config(make_config(1'b1, 16'd500, 32'h0001_0000, 8'd200, 20'd20000,
                               16'd100, 16'd200, 8'd1));
      send_event(make_event(OP_START, t, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 100, 16'd40000, 10'd300, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 1500, 16'd40000, 10'd300, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 1600, 16'd40000, 10'd300, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 2100, 16'd40000, 10'd300, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 2300, 16'd1000, 10'd300, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_CLEAR, t + 2310, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_CLEAR, t + 2320, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b1));
      send_event(make_event(OP_START, t + 2400, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 2500, 16'd0, 10'd200, 1'b1, 1'b0, 1'b1, 1'b0));
      send_event(make_event(OP_CLEAR, t + 2510, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b1));
      send_event(make_event(OP_START, t + 2600, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 2700, 16'd0, 10'd200, 1'b0, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_STOP, t + 2710, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_START, t + 2720, 16'd0, 10'd0, 1'b1, 1'b1, 1'b0, 1'b0));
   endtask

   task automatic test_extreme_settings();
      logic [31:0] t;
      t = 32'd1000;
      // full gain saturates the estimate; zero times and retries fault after one pause
      apply_config(make_config(1'b1, 16'd0, 32'hFFFF_FFFF, 8'd255, 20'd0,
                               16'd0, 16'd0, 8'd0));
      send_event(make_event(OP_START, t, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 1500, 16'hFFFF, 10'h3FF, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 1500, 16'hFFFF, 10'h3FF, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 2000, 16'd1, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 2000, 16'd1, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      // sensor-limit deficit is the only overload, reverse target 0; fault refuses start
      apply_config(make_config(1'b1, 16'hFFFF, 32'h0001_0000, 8'd1, 20'hFFFFF,
                               16'd0, 16'hFFFF, 8'hFF));
      send_event(make_event(OP_START, t, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 1500, 16'd30000, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 1500, 16'd30000, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_event(make_event(OP_TICK, t + 2000, 16'd30000, 10'd0, 1'b1, 1'b0, 1'b1, 1'b0));
      send_event(make_event(OP_STOP, t + 2010, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
   endtask

   // result side holds off while events keep coming, so the input side must stall
   task automatic test_backpressure();
      apply_config(random_config());
      send_idle_pct = 0;
      stall_pct     = 0;
      long_hold_req <= long_hold_req + 1;
      drive_runs(40);
   endtask

   task automatic test_random_traffic();
      run_ms = $urandom;
      for (int phase = 0; phase < 4; phase++) begin
         apply_config(random_config());
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 71; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 71; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         drive_runs(140);
         case (phase)
            0: apply_config(make_config(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 20'hFFFFF,
                                        16'hFFFF, 16'hFFFF, 8'hFF));
            1: apply_config(make_config(1'b1, 16'd0, 32'd0, 8'd0, 20'd0,
                                        16'd0, 16'd0, 8'd0));
            default: apply_config(random_config());
         endcase
         drive_runs(120);
      end
   endtask

   initial begin
      reset                     <= 1'b1;
      req_ch.valid              <= 1'b0;
      req_ch.opcode             <= OP_TICK;
      req_ch.now_ms             <= 32'd0;
      req_ch.current_ma         <= 16'd0;
      req_ch.cutter_speed       <= 10'd0;
      req_ch.permission_ok      <= 1'b0;
      req_ch.heater_or_screw_on <= 1'b0;
      req_ch.tach_fail          <= 1'b0;
      req_ch.lockout_confirmed  <= 1'b0;
      csr_we                    <= 1'b0;
      csr_index                 <= REG_DRIVE_READY;
      csr_wdata                 <= 32'd0;
      sq_cfg = make_config(1'b0, 16'd0, 32'd0, 8'd0, TORQUE_MAX, 16'd1000, 16'd1000, 8'd3);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_retry_sequence();
      test_extreme_settings();
      test_backpressure();
      test_random_traffic();

      settle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== jam_recovery_motor_sequencer.f =====
design/jrms_pkg.sv
design/jrms_if.sv
design/jrms_front.sv
design/jrms_queue.sv
design/jrms_back.sv
design/jam_recovery_motor_sequencer.sv
tb/jam_recovery_motor_sequencer_test.sv
